[hdl/hdat_pkg.sv]
// shared types and constants for the heap dump array truncator
package hdat_pkg;

  localparam int unsigned PhaseW = 5;

  localparam logic [4:0] PH_HDR         = 5'd0;
  localparam logic [4:0] PH_REC_TAG     = 5'd1;
  localparam logic [4:0] PH_REC_TIME    = 5'd2;
  localparam logic [4:0] PH_REC_LEN     = 5'd3;
  localparam logic [4:0] PH_REC_BODY    = 5'd4;
  localparam logic [4:0] PH_SUB_TAG     = 5'd5;
  localparam logic [4:0] PH_SKIP_TAG    = 5'd6;
  localparam logic [4:0] PH_CLS_HEAD    = 5'd7;
  localparam logic [4:0] PH_CLS_NCONST  = 5'd8;
  localparam logic [4:0] PH_CONST_INDEX = 5'd9;
  localparam logic [4:0] PH_CONST_TYPE  = 5'd10;
  localparam logic [4:0] PH_CONST_VALUE = 5'd11;
  localparam logic [4:0] PH_CLS_NSTAT   = 5'd12;
  localparam logic [4:0] PH_STAT_ID     = 5'd13;
  localparam logic [4:0] PH_STAT_TYPE   = 5'd14;
  localparam logic [4:0] PH_STAT_VALUE  = 5'd15;
  localparam logic [4:0] PH_CLS_NINST   = 5'd16;
  localparam logic [4:0] PH_INST_HEAD   = 5'd17;
  localparam logic [4:0] PH_INST_LEN    = 5'd18;
  localparam logic [4:0] PH_OARR_HEAD   = 5'd19;
  localparam logic [4:0] PH_OARR_LEN    = 5'd20;
  localparam logic [4:0] PH_PARR_HEAD   = 5'd21;
  localparam logic [4:0] PH_PARR_LEN    = 5'd22;
  localparam logic [4:0] PH_PARR_TYPE   = 5'd23;
  localparam logic [4:0] PH_PARR_KEEP   = 5'd24;
  localparam logic [4:0] PH_PARR_ZERO   = 5'd25;

  localparam logic [7:0] TAG_HEAP_DUMP     = 8'h0C;
  localparam logic [7:0] TAG_HEAP_DUMP_SEG = 8'h1C;

  localparam logic [0:0] REG_ID_SIZE = 1'b0;
  localparam logic [0:0] REG_TRIM    = 1'b1;

  localparam logic [3:0]  ID_SIZE_RST = 4'd8;
  localparam logic [15:0] TRIM_RST    = 16'd100;

  // one accepted byte as it moves from the queue to the parser
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  // one parsed byte result
  typedef struct packed {
    logic [7:0] data;
    logic       zeroed;
    logic       bad_subtag;
    logic       bad_type;
  } result_t;

  // byte size of a basic type code, known flag in the top bit
  function automatic logic [4:0] type_size(logic [7:0] t, logic [3:0] id);
    logic [4:0] r;
    r = '0;
    case (t)
      8'd2:         r = {1'b1, id};
      8'd4, 8'd8:   r = 5'h11;
      8'd5, 8'd9:   r = 5'h12;
      8'd6, 8'd10:  r = 5'h14;
      8'd7, 8'd11:  r = 5'h18;
      default:      r = 5'h00;
    endcase
    return r;
  endfunction

endpackage

[hdl/hdat_queue.sv]
// two-entry byte queue between the input front and the parser
module hdat_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  hdat_pkg::byte_item_t in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output hdat_pkg::byte_item_t out_item_o
);

  hdat_pkg::byte_item_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_item_o  = mem_q[rd_ptr_q];
  assign push = in_valid_i & in_ready_o;
  assign pop  = out_valid_o & out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[hdl/hdat_parser.sv]
// record/sub-record walker, output reg, one byte per cycle unless stalled
module hdat_parser #(
  parameter int unsigned HeaderBytes = 31
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [3:0]           id_size_i,
  input  logic [15:0]          trim_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  hdat_pkg::byte_item_t in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output hdat_pkg::result_t    out_res_o
);

  logic [4:0]  phase_q, phase_d;
  logic [5:0]  hdr_q, hdr_d;
  logic [7:0]  tag_q, tag_d;
  logic [31:0] rec_q, rec_d;
  logic [3:0]  fcnt_q, fcnt_d;
  logic [31:0] val_q, val_d;
  logic [35:0] skip_q, skip_d;
  logic [15:0] ent_q, ent_d;
  logic [3:0]  esz_q, esz_d;
  logic [35:0] keep_q, keep_d;
  logic [35:0] zero_q, zero_d;
  // product staging for array body sizes
  logic        pend_q, pend_d;
  logic        ovalid_q;
  hdat_pkg::result_t res_q, res_d;

  logic        fire;
  logic [5:0]  hdr_lim;
  assign hdr_lim = 6'(HeaderBytes);

  // the array split multiply is resolved in the cycle after the type byte;
  // the parser accepts no byte while it is resolved
  assign in_ready_o = !pend_q && (!ovalid_q || out_ready_i);
  assign fire = in_valid_i && in_ready_o;
  assign out_valid_o = ovalid_q;
  assign out_res_o   = res_q;

  logic [31:0] tk_val;
  logic [3:0]  tk_cnt;
  logic [7:0]  b;
  logic [35:0] idw;
  logic [4:0]  ts;
  logic [35:0] arr_n, arr_t, keep_p, zero_p;

  assign arr_n  = {4'd0, val_q};
  assign arr_t  = {20'd0, trim_i};
  assign keep_p = (arr_n < arr_t ? arr_n : arr_t) * {32'd0, esz_q};
  assign zero_p = (arr_n > arr_t) ? (arr_n - arr_t) * {32'd0, esz_q} : 36'd0;

  always_comb begin
    logic [4:0]  ph;
    logic [4:0]  fph;
    logic        do_skip;
    logic [35:0] sn;
    logic        fin;
    phase_d = phase_q; hdr_d = hdr_q; tag_d = tag_q; rec_d = rec_q;
    fcnt_d = fcnt_q; val_d = val_q; skip_d = skip_q; ent_d = ent_q;
    esz_d = esz_q; keep_d = keep_q; zero_d = zero_q; pend_d = 1'b0;
    res_d = res_q;
    b = in_item_i.data;
    idw = {32'd0, id_size_i};
    tk_val = {val_q[23:0], b};
    tk_cnt = fcnt_q + 4'd1;
    ts = hdat_pkg::type_size(b, id_size_i);
    do_skip = 1'b0; sn = '0; fph = phase_q; fin = 1'b0;
    ph = phase_q;
    res_d.data = b; res_d.zeroed = 1'b0; res_d.bad_subtag = 1'b0;
    res_d.bad_type = 1'b0;

    if (pend_q) begin
      keep_d = keep_p;
      zero_d = zero_p;
      if (keep_p != 36'd0)       phase_d = hdat_pkg::PH_PARR_KEEP;
      else if (zero_p != 36'd0)  phase_d = hdat_pkg::PH_PARR_ZERO;
      else                       phase_d = hdat_pkg::PH_SUB_TAG;
      // the record may already have ended on the type byte
      if (rec_q == 32'd0) phase_d = hdat_pkg::PH_REC_TAG;
    end else if (fire) begin
      if (ph == hdat_pkg::PH_HDR && hdr_q >= hdr_lim) ph = hdat_pkg::PH_REC_TAG;
      phase_d = ph;
      if (ph < hdat_pkg::PH_SUB_TAG) begin
        case (ph)
          hdat_pkg::PH_HDR: begin
            hdr_d = hdr_q + 6'd1;
            if (hdr_d >= hdr_lim) phase_d = hdat_pkg::PH_REC_TAG;
          end
          hdat_pkg::PH_REC_TAG: begin
            tag_d = b; phase_d = hdat_pkg::PH_REC_TIME; fcnt_d = '0; val_d = '0;
          end
          hdat_pkg::PH_REC_TIME: begin
            fcnt_d = tk_cnt; val_d = tk_val;
            if (tk_cnt >= 4'd4) begin
              phase_d = hdat_pkg::PH_REC_LEN; fcnt_d = '0; val_d = '0;
            end
          end
          hdat_pkg::PH_REC_LEN: begin
            fcnt_d = tk_cnt; val_d = tk_val;
            if (tk_cnt >= 4'd4) begin
              rec_d = tk_val;
              if (tk_val == 32'd0) phase_d = hdat_pkg::PH_REC_TAG;
              else if (tag_q == hdat_pkg::TAG_HEAP_DUMP ||
                       tag_q == hdat_pkg::TAG_HEAP_DUMP_SEG)
                phase_d = hdat_pkg::PH_SUB_TAG;
              else phase_d = hdat_pkg::PH_REC_BODY;
            end
          end
          default: begin
            if (rec_q != 32'd0) rec_d = rec_q - 32'd1;
            if (rec_d == 32'd0) phase_d = hdat_pkg::PH_REC_TAG;
          end
        endcase
      end else begin
        case (ph)
          hdat_pkg::PH_SUB_TAG: begin
            case (b)
              8'hFF, 8'h05, 8'h07: begin do_skip = 1'b1; fph = hdat_pkg::PH_SKIP_TAG;
                sn = idw; end
              8'h01: begin do_skip = 1'b1; fph = hdat_pkg::PH_SKIP_TAG; sn = idw << 1; end
              8'h02, 8'h03, 8'h08: begin do_skip = 1'b1; fph = hdat_pkg::PH_SKIP_TAG;
                sn = idw + 36'd8; end
              8'h04, 8'h06: begin do_skip = 1'b1; fph = hdat_pkg::PH_SKIP_TAG;
                sn = idw + 36'd4; end
              8'h20: begin do_skip = 1'b1; fph = hdat_pkg::PH_CLS_HEAD;
                sn = (idw << 3) - idw + 36'd8; end
              8'h21: begin do_skip = 1'b1; fph = hdat_pkg::PH_INST_HEAD;
                sn = (idw << 1) + 36'd4; end
              8'h22: begin do_skip = 1'b1; fph = hdat_pkg::PH_OARR_HEAD;
                sn = idw + 36'd4; end
              8'h23: begin do_skip = 1'b1; fph = hdat_pkg::PH_PARR_HEAD;
                sn = idw + 36'd4; end
              default: res_d.bad_subtag = 1'b1;
            endcase
          end
          hdat_pkg::PH_CLS_NCONST, hdat_pkg::PH_CLS_NSTAT: begin
            fcnt_d = tk_cnt; val_d = tk_val;
            if (tk_cnt >= 4'd2) begin
              ent_d = tk_val[15:0];
              fph = ph; fin = 1'b1;
            end
          end
          hdat_pkg::PH_CONST_INDEX: begin
            fcnt_d = tk_cnt; val_d = tk_val;
            if (tk_cnt >= 4'd2) phase_d = hdat_pkg::PH_CONST_TYPE;
          end
          hdat_pkg::PH_CONST_TYPE: begin
            do_skip = 1'b1; fph = hdat_pkg::PH_CONST_VALUE; sn = {32'd0, ts[3:0]};
          end
          hdat_pkg::PH_STAT_TYPE: begin
            do_skip = 1'b1; fph = hdat_pkg::PH_STAT_VALUE; sn = {32'd0, ts[3:0]};
          end
          hdat_pkg::PH_CLS_NINST: begin
            fcnt_d = tk_cnt; val_d = tk_val;
            if (tk_cnt >= 4'd2) begin
              do_skip = 1'b1; fph = hdat_pkg::PH_SKIP_TAG;
              sn = 36'({5'd0, tk_val[15:0]} * {16'd0, idw[4:0] + 5'd1});
            end
          end
          hdat_pkg::PH_INST_LEN: begin
            fcnt_d = tk_cnt; val_d = tk_val;
            if (tk_cnt >= 4'd4) begin
              do_skip = 1'b1; fph = hdat_pkg::PH_SKIP_TAG; sn = {4'd0, tk_val};
            end
          end
          hdat_pkg::PH_OARR_LEN: begin
            fcnt_d = tk_cnt; val_d = tk_val;
            if (tk_cnt >= 4'd4) begin
              do_skip = 1'b1; fph = hdat_pkg::PH_SKIP_TAG;
              sn = ({4'd0, tk_val} + 36'd1) * idw;
            end
          end
          hdat_pkg::PH_PARR_LEN: begin
            fcnt_d = tk_cnt; val_d = tk_val;
            if (tk_cnt >= 4'd4) phase_d = hdat_pkg::PH_PARR_TYPE;
          end
          hdat_pkg::PH_PARR_TYPE: begin
            esz_d = ts[3:0];
            res_d.bad_type = ~ts[4];
            pend_d = 1'b1;
          end
          hdat_pkg::PH_PARR_KEEP: begin
            if (keep_q != 36'd0) keep_d = keep_q - 36'd1;
            if (keep_d == 36'd0)
              phase_d = (zero_q != 36'd0) ? hdat_pkg::PH_PARR_ZERO : hdat_pkg::PH_SUB_TAG;
          end
          hdat_pkg::PH_PARR_ZERO: begin
            res_d.data = 8'd0; res_d.zeroed = 1'b1;
            if (zero_q != 36'd0) zero_d = zero_q - 36'd1;
            if (zero_d == 36'd0) phase_d = hdat_pkg::PH_SUB_TAG;
          end
          hdat_pkg::PH_SKIP_TAG, hdat_pkg::PH_CLS_HEAD, hdat_pkg::PH_CONST_VALUE,
          hdat_pkg::PH_STAT_ID, hdat_pkg::PH_STAT_VALUE, hdat_pkg::PH_INST_HEAD,
          hdat_pkg::PH_OARR_HEAD, hdat_pkg::PH_PARR_HEAD: begin
            if (skip_q != 36'd0) skip_d = skip_q - 36'd1;
            if (skip_d == 36'd0) begin fin = 1'b1; fph = ph; end
          end
          default: phase_d = hdat_pkg::PH_SUB_TAG;
        endcase
        // a zero-length skip finishes at once
        if (do_skip) begin
          phase_d = fph; skip_d = sn;
          if (sn == 36'd0) fin = 1'b1;
        end
        if (fin) begin
          case (fph)
            hdat_pkg::PH_CLS_HEAD: begin
              phase_d = hdat_pkg::PH_CLS_NCONST; fcnt_d = '0; val_d = '0;
            end
            hdat_pkg::PH_CONST_VALUE, hdat_pkg::PH_CLS_NCONST: begin
              if (ent_d != 16'd0) begin
                ent_d = ent_d - 16'd1; phase_d = hdat_pkg::PH_CONST_INDEX;
              end else phase_d = hdat_pkg::PH_CLS_NSTAT;
              fcnt_d = '0; val_d = '0;
            end
            hdat_pkg::PH_STAT_ID: phase_d = hdat_pkg::PH_STAT_TYPE;
            hdat_pkg::PH_STAT_VALUE, hdat_pkg::PH_CLS_NSTAT: begin
              if (ent_d != 16'd0) begin
                ent_d = ent_d - 16'd1;
                phase_d = hdat_pkg::PH_STAT_ID; skip_d = idw;
                if (idw == 36'd0) phase_d = hdat_pkg::PH_STAT_TYPE;
              end else begin
                phase_d = hdat_pkg::PH_CLS_NINST; fcnt_d = '0; val_d = '0;
              end
            end
            hdat_pkg::PH_INST_HEAD: begin
              phase_d = hdat_pkg::PH_INST_LEN; fcnt_d = '0; val_d = '0;
            end
            hdat_pkg::PH_OARR_HEAD: begin
              phase_d = hdat_pkg::PH_OARR_LEN; fcnt_d = '0; val_d = '0;
            end
            hdat_pkg::PH_PARR_HEAD: begin
              phase_d = hdat_pkg::PH_PARR_LEN; fcnt_d = '0; val_d = '0;
            end
            default: phase_d = hdat_pkg::PH_SUB_TAG;
          endcase
        end
        if (rec_q != 32'd0) rec_d = rec_q - 32'd1;
        if (rec_d == 32'd0) begin
          phase_d = hdat_pkg::PH_REC_TAG;
          pend_d = 1'b0;
        end
      end
      if (in_item_i.last) begin
        phase_d = hdat_pkg::PH_HDR; hdr_d = '0; tag_d = '0; rec_d = '0;
        fcnt_d = '0; val_d = '0; skip_d = '0; ent_d = '0; esz_d = '0;
        keep_d = '0; zero_d = '0; pend_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hdat_pkg::PH_HDR; hdr_q <= '0; tag_q <= '0; rec_q <= '0;
      fcnt_q <= '0; val_q <= '0; skip_q <= '0; ent_q <= '0; esz_q <= '0;
      keep_q <= '0; zero_q <= '0; pend_q <= 1'b0; ovalid_q <= 1'b0;
    end else begin
      phase_q <= phase_d; hdr_q <= hdr_d; tag_q <= tag_d; rec_q <= rec_d;
      fcnt_q <= fcnt_d; val_q <= val_d; skip_q <= skip_d; ent_q <= ent_d;
      esz_q <= esz_d; keep_q <= keep_d; zero_q <= zero_d; pend_q <= pend_d;
      if (fire) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
    end
  end

endmodule

[hdl/heap_dump_array_truncator_unit.sv]
// top level: config registers, input queue and parser
// Streams a heap profile file and returns one result byte per input byte, zeroing primitive
// array elements past the configured trim count. Throughput is one byte per cycle while the
// output is ready, except that after each primitive array type byte the parser takes no
// input while the array body split is multiplied out. A two-entry queue decouples input
// acceptance from the parser, and an output register holds the result.
// Write id_size (index 0) and the trim count (index 1) only while idle.
module heap_dump_array_truncator_unit #(
  parameter int unsigned HEADER_BYTES = 31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        was_zeroed_o,
  output logic        bad_subtag_o,
  output logic        bad_array_type_o
);

  logic [3:0]  id_size_q;
  logic [15:0] trim_q;
  hdat_pkg::byte_item_t in_item, q_item;
  hdat_pkg::result_t    res;
  logic q_valid, q_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_size_q <= hdat_pkg::ID_SIZE_RST;
      trim_q    <= hdat_pkg::TRIM_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        hdat_pkg::REG_ID_SIZE: id_size_q <= cfg_data_i[3:0];
        hdat_pkg::REG_TRIM:    trim_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_item.data = data_byte_i;
  assign in_item.last = last_byte_i;

  hdat_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i (in_valid_i), .in_ready_o (in_ready_o), .in_item_i (in_item),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_item_o(q_item)
  );

  hdat_parser #(.HeaderBytes(HEADER_BYTES)) u_parser (
    .clk_i, .rst_ni,
    .id_size_i(id_size_q), .trim_i(trim_q),
    .in_valid_i(q_valid), .in_ready_o(q_ready), .in_item_i(q_item),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_res_o(res)
  );

  assign out_byte_o       = res.data;
  assign was_zeroed_o     = res.zeroed;
  assign bad_subtag_o     = res.bad_subtag;
  assign bad_array_type_o = res.bad_type;

endmodule

[test/tb_heap_dump_array_truncator_unit.sv]
// testbench for the heap dump array truncator: directed and random profile files checked byte by byte
module tb_heap_dump_array_truncator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HdrBytes = 31;
  localparam int unsigned ShowLimit = 10;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned DrainCycles = 12;

  // follows the parser state and keeps the expected output bytes
  class truncation_scoreboard;
    logic [3:0]  id_size;
    logic [15:0] trim_count;
    logic [4:0]  phase;
    int unsigned hdr_seen;
    logic [7:0]  rec_tag;
    int unsigned rec_left;
    int unsigned field_cnt;
    int unsigned field_val;
    longint unsigned skip_left;
    int unsigned entries_left;
    int unsigned elt_bytes;
    longint unsigned keep_left;
    longint unsigned zero_left;
    hdat_pkg::result_t expected_bytes[$];
    int unsigned mismatch_count;

    function new();
      id_size = hdat_pkg::ID_SIZE_RST;
      trim_count = hdat_pkg::TRIM_RST;
      mismatch_count = 0;
      clear();
    endfunction

    function void clear();
      phase = hdat_pkg::PH_HDR;
      hdr_seen = 0;
      rec_tag = '0;
      rec_left = 0;
      field_cnt = 0;
      field_val = 0;
      skip_left = 0;
      entries_left = 0;
      elt_bytes = 0;
      keep_left = 0;
      zero_left = 0;
    endfunction

    function void set_reg(logic [0:0] idx, logic [15:0] val);
      if (idx == hdat_pkg::REG_ID_SIZE) id_size = val[3:0];
      else trim_count = val;
    endfunction

    function void open_field(logic [4:0] ph);
      phase = ph;
      field_cnt = 0;
      field_val = 0;
    endfunction

    function bit shift_in(logic [7:0] b, int unsigned n);
      field_val = (field_val << 8) | b;
      field_cnt = (field_cnt + 1) & 15;
      return field_cnt >= n;
    endfunction

    function int unsigned value_bytes(logic [7:0] t, output bit known);
      known = 1;
      case (t)
        8'd2: return id_size;
        8'd4, 8'd8: return 1;
        8'd5, 8'd9: return 2;
        8'd6, 8'd10: return 4;
        8'd7, 8'd11: return 8;
        default: begin
          known = 0;
          return 0;
        end
      endcase
    endfunction

    function void next_const();
      if (entries_left != 0) begin
        entries_left--;
        open_field(hdat_pkg::PH_CONST_INDEX);
      end else open_field(hdat_pkg::PH_CLS_NSTAT);
    endfunction

    function void next_static();
      if (entries_left != 0) begin
        entries_left--;
        start_skip(hdat_pkg::PH_STAT_ID, id_size);
      end else open_field(hdat_pkg::PH_CLS_NINST);
    endfunction

    function void skip_done(logic [4:0] ph);
      case (ph)
        hdat_pkg::PH_CLS_HEAD: open_field(hdat_pkg::PH_CLS_NCONST);
        hdat_pkg::PH_CONST_VALUE: next_const();
        hdat_pkg::PH_STAT_ID: phase = hdat_pkg::PH_STAT_TYPE;
        hdat_pkg::PH_STAT_VALUE: next_static();
        hdat_pkg::PH_INST_HEAD: open_field(hdat_pkg::PH_INST_LEN);
        hdat_pkg::PH_OARR_HEAD: open_field(hdat_pkg::PH_OARR_LEN);
        hdat_pkg::PH_PARR_HEAD: open_field(hdat_pkg::PH_PARR_LEN);
        default: phase = hdat_pkg::PH_SUB_TAG;
      endcase
    endfunction

    function void start_skip(logic [4:0] ph, longint unsigned n);
      phase = ph;
      skip_left = n;
      if (n == 0) skip_done(ph);
    endfunction

    // accepted input byte: advance the parser and queue its result
    function void note_input(logic [7:0] b, logic last);
      hdat_pkg::result_t r;
      longint unsigned id, n, t;
      bit known;
      id = id_size;
      r = '{data: b, zeroed: 1'b0, bad_subtag: 1'b0, bad_type: 1'b0};
      if (phase == hdat_pkg::PH_HDR && hdr_seen >= HdrBytes) phase = hdat_pkg::PH_REC_TAG;
      if (phase < hdat_pkg::PH_SUB_TAG) begin
        case (phase)
          hdat_pkg::PH_HDR: begin
            hdr_seen = (hdr_seen + 1) & 63;
            if (hdr_seen >= HdrBytes) phase = hdat_pkg::PH_REC_TAG;
          end
          hdat_pkg::PH_REC_TAG: begin
            rec_tag = b;
            open_field(hdat_pkg::PH_REC_TIME);
          end
          hdat_pkg::PH_REC_TIME: if (shift_in(b, 4)) open_field(hdat_pkg::PH_REC_LEN);
          hdat_pkg::PH_REC_LEN: if (shift_in(b, 4)) begin
            rec_left = field_val;
            if (rec_left == 0) phase = hdat_pkg::PH_REC_TAG;
            else if (rec_tag == hdat_pkg::TAG_HEAP_DUMP ||
                     rec_tag == hdat_pkg::TAG_HEAP_DUMP_SEG)
              phase = hdat_pkg::PH_SUB_TAG;
            else phase = hdat_pkg::PH_REC_BODY;
          end
          default: begin
            if (rec_left != 0) rec_left--;
            if (rec_left == 0) phase = hdat_pkg::PH_REC_TAG;
          end
        endcase
      end else begin
        case (phase)
          hdat_pkg::PH_SUB_TAG: case (b)
            8'hFF, 8'h05, 8'h07: start_skip(hdat_pkg::PH_SKIP_TAG, id);
            8'h01: start_skip(hdat_pkg::PH_SKIP_TAG, 2 * id);
            8'h02, 8'h03, 8'h08: start_skip(hdat_pkg::PH_SKIP_TAG, id + 8);
            8'h04, 8'h06: start_skip(hdat_pkg::PH_SKIP_TAG, id + 4);
            8'h20: start_skip(hdat_pkg::PH_CLS_HEAD, 7 * id + 8);
            8'h21: start_skip(hdat_pkg::PH_INST_HEAD, 2 * id + 4);
            8'h22: start_skip(hdat_pkg::PH_OARR_HEAD, id + 4);
            8'h23: start_skip(hdat_pkg::PH_PARR_HEAD, id + 4);
            default: r.bad_subtag = 1'b1;
          endcase
          hdat_pkg::PH_CLS_NCONST: if (shift_in(b, 2)) begin
            entries_left = field_val & 16'hFFFF;
            next_const();
          end
          hdat_pkg::PH_CONST_INDEX: if (shift_in(b, 2)) phase = hdat_pkg::PH_CONST_TYPE;
          hdat_pkg::PH_CONST_TYPE:
            start_skip(hdat_pkg::PH_CONST_VALUE, value_bytes(b, known));
          hdat_pkg::PH_CLS_NSTAT: if (shift_in(b, 2)) begin
            entries_left = field_val & 16'hFFFF;
            next_static();
          end
          hdat_pkg::PH_STAT_TYPE:
            start_skip(hdat_pkg::PH_STAT_VALUE, value_bytes(b, known));
          hdat_pkg::PH_CLS_NINST: if (shift_in(b, 2))
            start_skip(hdat_pkg::PH_SKIP_TAG, longint'(field_val & 16'hFFFF) * (id + 1));
          hdat_pkg::PH_INST_LEN: if (shift_in(b, 4))
            start_skip(hdat_pkg::PH_SKIP_TAG, field_val);
          hdat_pkg::PH_OARR_LEN: if (shift_in(b, 4))
            start_skip(hdat_pkg::PH_SKIP_TAG, (longint'(field_val) + 1) * id);
          hdat_pkg::PH_PARR_LEN: if (shift_in(b, 4)) phase = hdat_pkg::PH_PARR_TYPE;
          hdat_pkg::PH_PARR_TYPE: begin
            elt_bytes = value_bytes(b, known) & 15;
            if (!known) r.bad_type = 1'b1;
            n = field_val;
            t = trim_count;
            keep_left = (n < t ? n : t) * elt_bytes;
            zero_left = n > t ? (n - t) * elt_bytes : 0;
            if (keep_left != 0) phase = hdat_pkg::PH_PARR_KEEP;
            else if (zero_left != 0) phase = hdat_pkg::PH_PARR_ZERO;
            else phase = hdat_pkg::PH_SUB_TAG;
          end
          hdat_pkg::PH_PARR_KEEP: begin
            if (keep_left != 0) keep_left--;
            if (keep_left == 0)
              phase = zero_left != 0 ? hdat_pkg::PH_PARR_ZERO : hdat_pkg::PH_SUB_TAG;
          end
          hdat_pkg::PH_PARR_ZERO: begin
            r.data = '0;
            r.zeroed = 1'b1;
            if (zero_left != 0) zero_left--;
            if (zero_left == 0) phase = hdat_pkg::PH_SUB_TAG;
          end
          hdat_pkg::PH_SKIP_TAG, hdat_pkg::PH_CLS_HEAD, hdat_pkg::PH_CONST_VALUE,
          hdat_pkg::PH_STAT_ID, hdat_pkg::PH_STAT_VALUE, hdat_pkg::PH_INST_HEAD,
          hdat_pkg::PH_OARR_HEAD, hdat_pkg::PH_PARR_HEAD: begin
            if (skip_left != 0) skip_left--;
            if (skip_left == 0) skip_done(phase);
          end
          default: phase = hdat_pkg::PH_SUB_TAG;
        endcase
        if (rec_left != 0) rec_left--;
        if (rec_left == 0) phase = hdat_pkg::PH_REC_TAG;
      end
      if (last) clear();
      expected_bytes.push_back(r);
    endfunction

    function void check_result(hdat_pkg::result_t got);
      hdat_pkg::result_t want;
      if (expected_bytes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ShowLimit)
          $display("unexpected output transaction: byte %h zeroed %b bad_sub %b bad_type %b",
                   got.data, got.zeroed, got.bad_subtag, got.bad_type);
        return;
      end
      want = expected_bytes.pop_front();
      if (got != want) begin
        mismatch_count++;
        if (mismatch_count <= ShowLimit)
          $display("output mismatch: expected byte %h z%b s%b t%b, got byte %h z%b s%b t%b",
                   want.data, want.zeroed, want.bad_subtag, want.bad_type,
                   got.data, got.zeroed, got.bad_subtag, got.bad_type);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = hdat_pkg::REG_ID_SIZE;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        was_zeroed_o;
  logic        bad_subtag_o;
  logic        bad_array_type_o;

  truncation_scoreboard sb = new();
  logic [7:0]  file_bytes[$];
  logic [7:0]  body[$];
  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_tick = 0;
  int unsigned idle_cycles = 0;
  int unsigned bytes_sent = 0;

  heap_dump_array_truncator_unit u_dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // receiver: stall pattern changes mode now and then
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i)
      sb.check_result('{data: out_byte_o, zeroed: was_zeroed_o,
                        bad_subtag: bad_subtag_o, bad_type: bad_array_type_o});
    stall_tick++;
    if (stall_tick % 300 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 1) == 1);
      2: out_ready_i <= (stall_tick % 5 != 0);
      default: out_ready_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    while (sb.expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic send_byte(logic [7:0] b, logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(b, last);
    bytes_sent++;
  endtask

  function automatic void put_rand(int unsigned n);
    repeat (n) body.push_back(8'($urandom));
  endfunction

  function automatic void put_be(int unsigned v, int unsigned n);
    for (int i = n - 1; i >= 0; i--) body.push_back(8'(v >> (8 * i)));
  endfunction

  // pick a basic type code, mostly known ones; returns its byte size
  function automatic int unsigned put_type(int unsigned id);
    logic [7:0] t;
    bit known;
    t = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(2, 11));
    if (t == 8'd3) t = 8'd2;
    body.push_back(t);
    return sb.value_bytes(t, known);
  endfunction

  function automatic void put_sub_record(logic [7:0] tag);
    int unsigned id, n, sz;
    id = sb.id_size;
    body.push_back(tag);
    case (tag)
      8'hFF, 8'h05, 8'h07: put_rand(id);
      8'h01: put_rand(2 * id);
      8'h02, 8'h03, 8'h08: put_rand(id + 8);
      8'h04, 8'h06: put_rand(id + 4);
      8'h20: begin
        put_rand(7 * id + 8);
        n = $urandom_range(0, 2);
        put_be(n, 2);
        repeat (n) begin
          put_rand(2);
          sz = put_type(id);
          put_rand(sz);
        end
        n = $urandom_range(0, 2);
        put_be(n, 2);
        repeat (n) begin
          put_rand(id);
          sz = put_type(id);
          put_rand(sz);
        end
        n = $urandom_range(0, 3);
        put_be(n, 2);
        put_rand(n * (id + 1));
      end
      8'h21: begin
        put_rand(2 * id + 4);
        n = $urandom_range(0, 6);
        put_be(n, 4);
        put_rand(n);
      end
      8'h22: begin
        put_rand(id + 4);
        n = $urandom_range(0, 3);
        put_be(n, 4);
        put_rand((n + 1) * id);
      end
      8'h23: begin
        put_rand(id + 4);
        n = $urandom_range(0, 8);
        put_be(n, 4);
        sz = put_type(id);
        put_rand(n * sz);
      end
      default: ;
    endcase
  endfunction

  function automatic void add_record(logic [7:0] tag, int unsigned len);
    file_bytes.push_back(tag);
    repeat (4) file_bytes.push_back(8'($urandom));
    for (int i = 3; i >= 0; i--) file_bytes.push_back(8'(len >> (8 * i)));
    foreach (body[i]) file_bytes.push_back(body[i]);
  endfunction

  // a whole profile file; the first one walks every sub-record kind in order
  function automatic void build_file(bit directed);
    logic [7:0] sub_tags[$];
    int unsigned len;
    sub_tags = '{8'hFF, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08,
                 8'h20, 8'h21, 8'h22, 8'h23, 8'h99};
    file_bytes.delete();
    repeat (HdrBytes) file_bytes.push_back(8'($urandom));
    if (directed) begin
      body.delete();
      foreach (sub_tags[i]) put_sub_record(sub_tags[i]);
      add_record(hdat_pkg::TAG_HEAP_DUMP, body.size());
      body.delete();
      add_record(8'h01, 0);
      return;
    end
    repeat ($urandom_range(2, 5)) begin
      body.delete();
      if ($urandom_range(0, 3) != 0) begin
        repeat ($urandom_range(2, 7))
          put_sub_record(($urandom_range(0, 9) == 0) ? 8'($urandom)
                         : sub_tags[$urandom_range(0, sub_tags.size() - 2)]);
        len = body.size();
        // sometimes the length disagrees with the body so sub-records get cut
        if ($urandom_range(0, 6) == 0) len = $urandom_range(0, len);
        add_record(($urandom_range(0, 1) == 1) ? hdat_pkg::TAG_HEAP_DUMP
                   : hdat_pkg::TAG_HEAP_DUMP_SEG, len);
      end else begin
        put_rand($urandom_range(0, 10));
        add_record(8'($urandom_range(1, 11)), body.size());
      end
    end
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 8))
      file_bytes.push_back(8'($urandom));
  endfunction

  task automatic run_file(bit directed);
    build_file(directed);
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
    in_valid_i <= 1'b0;
    burst_left = 0;
  endtask

  initial begin
    logic [3:0]  id_plan[4];
    logic [15:0] trim_plan[4];
    int unsigned phase_idx;
    id_plan = '{4'd1, 4'd8, 4'd4, 4'd2};
    trim_plan = '{16'd0, 16'd65535, 16'd2, 16'd1};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // reset values first, then a fresh register setting per file
    run_file(1'b1);
    phase_idx = 0;
    while (bytes_sent < 1150) begin
      wait_idle();
      if (phase_idx < 4) begin
        write_reg(hdat_pkg::REG_ID_SIZE, 16'(id_plan[phase_idx]));
        write_reg(hdat_pkg::REG_TRIM, trim_plan[phase_idx]);
      end else begin
        write_reg(hdat_pkg::REG_ID_SIZE, 16'($urandom_range(1, 8)));
        write_reg(hdat_pkg::REG_TRIM, 16'($urandom_range(0, 6)));
      end
      phase_idx++;
      run_file(1'b0);
    end
    wait_idle();
    if (sb.mismatch_count == 0 && sb.expected_bytes.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
